// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the RTL files.
// ----------------------------------------------------------------------------
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent.
`define LCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/core/lcc_pkg.sv =====
// ----------------------------------------------------------------------------
// lcc_pkg
// Types, constants and helper functions shared by the card number checker.
// ----------------------------------------------------------------------------
package lcc_pkg;

    localparam int CARD_W        = 54;
    localparam int BCD_DIGITS    = 17;
    localparam int BCD_W         = BCD_DIGITS * 4;
    localparam int BITS_PER_STEP = 2;
    localparam int CONV_STEPS    = CARD_W / BITS_PER_STEP;
    localparam int CNT_W         = 5;

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [3:0]        digit_t;
    typedef logic [BCD_W-1:0]  bcd_t;
    typedef logic [CARD_W-1:0] card_t;

    typedef enum logic [1:0] {
        VERDICT_INVALID = 2'd0,
        VERDICT_VISA    = 2'd1,
        VERDICT_AMEX    = 2'd2,
        VERDICT_MASTER  = 2'd3
    } verdict_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_WALK,
        ST_FINISH
    } state_t;

    // Digit counts of the accepted card formats
    localparam cnt_t LEN_SHORT = cnt_t'(13);
    localparam cnt_t LEN_AMEX  = cnt_t'(15);
    localparam cnt_t LEN_LONG  = cnt_t'(16);

    // Leading digit values
    localparam digit_t LEAD_VISA    = 4'd4;
    localparam digit_t LEAD_AMEX_HI = 4'd3;
    localparam digit_t LEAD_AMEX_LA = 4'd4;
    localparam digit_t LEAD_AMEX_LB = 4'd7;
    localparam digit_t LEAD_MC_HI   = 4'd5;
    localparam digit_t LEAD_MC_LMIN = 4'd1;
    localparam digit_t LEAD_MC_LMAX = 4'd5;

    typedef struct packed {
        logic load;
        logic conv;
        logic shift;
    } dab_ctl_t;

    typedef struct packed {
        logic clear;
        logic step;
        cnt_t pos;
    } walk_ctl_t;

    typedef struct packed {
        cnt_t   count;
        digit_t lead_hi;
        digit_t lead_lo;
        logic   luhn_ok;
    } walk_stat_t;

    // One double-dabble bit: add 3 to every digit of 5 or more, then shift in b
    function automatic bcd_t dabble_bit(input bcd_t bcd, input logic b);
        bcd_t adj;
        adj = bcd;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (adj[i*4 +: 4] >= 4'd5)
            begin
                adj[i*4 +: 4] = adj[i*4 +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], b};
    endfunction

    // Luhn contribution of one digit; doubled digits fold their tens back in
    function automatic digit_t luhn_term(input digit_t d, input logic dbl);
        logic [4:0] twice;
        twice = {d, 1'b0};
        if (!dbl)
        begin
            return d;
        end
        else if (d < 4'd5)
        begin
            return twice[3:0];
        end
        else
        begin
            return 4'(twice - 5'd9);
        end
    endfunction

endpackage

// ===== rtl/core/card_number_luhn_classifier_top.sv =====
// ----------------------------------------------------------------------------
// card_number_luhn_classifier_top
// Luhn mod-10 check and card class decode of one binary card number.
//
//   channel | signals                         | direction
//   --------+---------------------------------+----------
//   request | in_valid, in_stall, card_number | in
//   result  | out_valid, out_stall, verdict   | out
//
// After the accepting edge: 27 conversion steps of the shift-add-3 unit
// (two bits each), 17 digit walk steps, then 1 classify that sets out_valid.
// The block takes no new request until that classify step is done.
// in_stall is low only while idle. A waiting result does not block the next
// request; its classify step holds until the output register is free.
// Reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module card_number_luhn_classifier_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [lcc_pkg::CARD_W-1:0]  card_number,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  verdict
);

    localparam lcc_pkg::cnt_t CONV_LAST = lcc_pkg::cnt_t'(lcc_pkg::CONV_STEPS - 1);
    localparam lcc_pkg::cnt_t WALK_LAST = lcc_pkg::cnt_t'(lcc_pkg::BCD_DIGITS - 1);

    lcc_pkg::state_t     state_reg;
    lcc_pkg::state_t     state_next;
    lcc_pkg::cnt_t       cnt_reg;
    lcc_pkg::cnt_t       cnt_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    lcc_pkg::verdict_t   verdict_reg;
    lcc_pkg::verdict_t   verdict_next;
    lcc_pkg::verdict_t   verdict_calc;
    lcc_pkg::dab_ctl_t   dab_ctl;
    lcc_pkg::walk_ctl_t  walk_ctl;
    lcc_pkg::walk_stat_t stat;
    lcc_pkg::digit_t     digit;
    logic                accept;
    logic                out_free;
    logic                out_write;
    logic                len_ok;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    lcc_dabble u_dabble
    (
        .clk         (clk),
        .ctl         (dab_ctl),
        .card_number (card_number),
        .digit       (digit)
    );

    lcc_walk u_walk
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (walk_ctl),
        .digit (digit),
        .stat  (stat)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lcc_pkg::ST_CONVERT;
                end
            end
            lcc_pkg::ST_CONVERT:
            begin
                if (cnt_reg == CONV_LAST)
                begin
                    state_next = lcc_pkg::ST_WALK;
                end
            end
            lcc_pkg::ST_WALK:
            begin
                if (cnt_reg == WALK_LAST)
                begin
                    state_next = lcc_pkg::ST_FINISH;
                end
            end
            lcc_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = lcc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcc_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall       = 1'b1;
        dab_ctl        = '0;
        walk_ctl.clear = 1'b0;
        walk_ctl.step  = 1'b0;
        walk_ctl.pos   = cnt_reg;
        cnt_next       = cnt_reg;
        out_write      = 1'b0;
        case (state_reg)
            lcc_pkg::ST_IDLE:
            begin
                in_stall       = 1'b0;
                dab_ctl.load   = in_valid;
                walk_ctl.clear = in_valid;
                cnt_next       = '0;
            end
            lcc_pkg::ST_CONVERT:
            begin
                dab_ctl.conv = 1'b1;
                cnt_next     = (cnt_reg == CONV_LAST) ? '0 : cnt_reg + lcc_pkg::cnt_t'(1);
            end
            lcc_pkg::ST_WALK:
            begin
                dab_ctl.shift = 1'b1;
                walk_ctl.step = 1'b1;
                cnt_next      = cnt_reg + lcc_pkg::cnt_t'(1);
            end
            lcc_pkg::ST_FINISH:
            begin
                out_write = out_free;
                cnt_next  = '0;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // class decode from count, leading pair and Luhn sum
    always_comb
    begin
        verdict_calc = lcc_pkg::VERDICT_INVALID;
        if (stat.luhn_ok)
        begin
            if (stat.count == lcc_pkg::LEN_SHORT)
            begin
                if (stat.lead_hi == lcc_pkg::LEAD_VISA)
                begin
                    verdict_calc = lcc_pkg::VERDICT_VISA;
                end
            end
            else if (stat.count == lcc_pkg::LEN_AMEX)
            begin
                if (stat.lead_hi == lcc_pkg::LEAD_AMEX_HI
                    && (stat.lead_lo == lcc_pkg::LEAD_AMEX_LA
                        || stat.lead_lo == lcc_pkg::LEAD_AMEX_LB))
                begin
                    verdict_calc = lcc_pkg::VERDICT_AMEX;
                end
            end
            else if (stat.count == lcc_pkg::LEN_LONG)
            begin
                if (stat.lead_hi == lcc_pkg::LEAD_MC_HI
                    && stat.lead_lo >= lcc_pkg::LEAD_MC_LMIN
                    && stat.lead_lo <= lcc_pkg::LEAD_MC_LMAX)
                begin
                    verdict_calc = lcc_pkg::VERDICT_MASTER;
                end
                else if (stat.lead_hi == lcc_pkg::LEAD_VISA)
                begin
                    verdict_calc = lcc_pkg::VERDICT_VISA;
                end
            end
        end
    end

    assign len_ok = (stat.count == lcc_pkg::LEN_SHORT)
                    || (stat.count == lcc_pkg::LEN_AMEX)
                    || (stat.count == lcc_pkg::LEN_LONG);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        verdict_next   = verdict_reg;
        if (out_write)
        begin
            out_valid_next = 1'b1;
            verdict_next   = verdict_calc;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcc_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    `LCC_ASSERT_NEXT(a_accept_starts_convert, accept, state_reg == lcc_pkg::ST_CONVERT)
    `LCC_ASSERT_NOW(a_walk_in_range, state_reg == lcc_pkg::ST_WALK, cnt_reg <= WALK_LAST)
    `LCC_ASSERT_NOW(a_class_needs_length, out_write && verdict_calc != 2'd0, len_ok)

endmodule

// ===== rtl/core/lcc_dabble.sv =====
// ----------------------------------------------------------------------------
// lcc_dabble
// Shared shift-add-3 unit: converts the card number to BCD two bits per
// cycle, then shifts the BCD word down one digit per cycle for the walk.
// ----------------------------------------------------------------------------
module lcc_dabble
(
    input  logic             clk,
    input  lcc_pkg::dab_ctl_t ctl,
    input  lcc_pkg::card_t   card_number,
    output lcc_pkg::digit_t  digit
);

    lcc_pkg::card_t bin_reg;
    lcc_pkg::card_t bin_next;
    lcc_pkg::bcd_t  bcd_reg;
    lcc_pkg::bcd_t  bcd_next;
    lcc_pkg::bcd_t  bcd_half;

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        bcd_half = lcc_pkg::dabble_bit(bcd_reg, bin_reg[lcc_pkg::CARD_W-1]);
        if (ctl.load)
        begin
            bin_next = card_number;
            bcd_next = '0;
        end
        else if (ctl.conv)
        begin
            bcd_next = lcc_pkg::dabble_bit(bcd_half, bin_reg[lcc_pkg::CARD_W-2]);
            bin_next = {bin_reg[lcc_pkg::CARD_W-3:0], 2'b00};
        end
        else if (ctl.shift)
        begin
            // drop the digit just consumed
            bcd_next = {4'd0, bcd_reg[lcc_pkg::BCD_W-1:4]};
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign digit = bcd_reg[3:0];

endmodule

// ===== rtl/core/lcc_walk.sv =====
// ----------------------------------------------------------------------------
// lcc_walk
// Digit walk: counts significant digits, keeps the two leading digits and
// accumulates the Luhn sum modulo ten, one digit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcc_walk
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lcc_pkg::walk_ctl_t   ctl,
    input  lcc_pkg::digit_t      digit,
    output lcc_pkg::walk_stat_t  stat
);

    lcc_pkg::cnt_t   count_reg;
    lcc_pkg::cnt_t   count_next;
    lcc_pkg::digit_t lead_hi_reg;
    lcc_pkg::digit_t lead_hi_next;
    lcc_pkg::digit_t lead_lo_reg;
    lcc_pkg::digit_t lead_lo_next;
    lcc_pkg::digit_t prev_reg;
    lcc_pkg::digit_t prev_next;
    lcc_pkg::digit_t total_reg;
    lcc_pkg::digit_t total_next;
    lcc_pkg::digit_t term;
    logic [4:0]      sum;

    always_comb
    begin
        // positions count from one, so an odd index is an even position
        term         = lcc_pkg::luhn_term(digit, ctl.pos[0]);
        sum          = {1'b0, total_reg} + {1'b0, term};
        count_next   = count_reg;
        lead_hi_next = lead_hi_reg;
        lead_lo_next = lead_lo_reg;
        prev_next    = prev_reg;
        total_next   = total_reg;
        if (ctl.clear)
        begin
            count_next   = '0;
            lead_hi_next = '0;
            lead_lo_next = '0;
            prev_next    = '0;
            total_next   = '0;
        end
        else if (ctl.step)
        begin
            prev_next  = digit;
            total_next = (sum >= 5'd10) ? 4'(sum - 5'd10) : sum[3:0];
            if (digit != 4'd0)
            begin
                count_next   = ctl.pos + lcc_pkg::cnt_t'(1);
                lead_hi_next = digit;
                lead_lo_next = prev_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            lead_hi_reg <= '0;
            lead_lo_reg <= '0;
            prev_reg    <= '0;
            total_reg   <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            lead_hi_reg <= lead_hi_next;
            lead_lo_reg <= lead_lo_next;
            prev_reg    <= prev_next;
            total_reg   <= total_next;
        end
    end

    assign stat.count   = count_reg;
    assign stat.lead_hi = lead_hi_reg;
    assign stat.lead_lo = lead_lo_reg;
    assign stat.luhn_ok = (total_reg == 4'd0);

    `LCC_ASSERT_NOW(a_total_mod_ten, 1'b1, total_reg < 4'd10)
    `LCC_ASSERT_NEXT(a_count_follows_pos, ctl.step && !ctl.clear && digit != 4'd0, count_reg != '0)

endmodule
